/* rtl/assert_macros.svh */
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define KCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define KCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define KCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/kcl_pkg.sv */
package kcl_pkg;

  localparam int KEY_W    = 4;
  localparam int CFG_N    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_FIRST  = 2'd0,
    CFG_CODE_SECOND = 2'd1,
    CFG_CODE_THIRD  = 2'd2,
    CFG_CODE_FOURTH = 2'd3
  } cfg_idx_e;

  localparam key_t CODE_RESET [CFG_N] = '{4'd0, 4'd1, 4'd2, 4'd4};

  typedef enum logic [1:0] {
    IND_NONE  = 2'd0,
    IND_BLUE  = 2'd1,
    IND_GREEN = 2'd2,
    IND_RED   = 2'd3
  } ind_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_PER_DOWN = 3'd1,
    CMD_PER_UP   = 3'd2,
    CMD_TOGGLE   = 3'd3,
    CMD_UP_COUNT = 3'd4,
    CMD_IN_OUT   = 3'd5,
    CMD_STATIC   = 3'd6
  } cmd_e;

  localparam key_t KEY_1 = 4'd0;
  localparam key_t KEY_2 = 4'd1;
  localparam key_t KEY_3 = 4'd2;
  localparam key_t KEY_A = 4'd3;
  localparam key_t KEY_B = 4'd7;
  localparam key_t KEY_0 = 4'd13;
  localparam key_t KEY_D = 4'd15;

  localparam logic [1:0] LAST_ENTRY = 2'd3;

  typedef struct packed {
    logic key_valid;
    key_t key_index;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    key_t                 data;
  } cfg_wr_t;

  typedef struct packed {
    logic  not_empty;
    item_t head;
  } q_status_t;

  function automatic cmd_e unlocked_command(key_t key);
    cmd_e cmd;
    unique case (key)
      KEY_A:   cmd = CMD_PER_DOWN;
      KEY_B:   cmd = CMD_PER_UP;
      KEY_1:   cmd = CMD_TOGGLE;
      KEY_2:   cmd = CMD_UP_COUNT;
      KEY_3:   cmd = CMD_IN_OUT;
      KEY_0:   cmd = CMD_STATIC;
      default: cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

endpackage

/* rtl/kcl_front.sv */
module kcl_front (
  input  logic [15:0]   key_matrix_i,
  output kcl_pkg::item_t item_o
);
  import kcl_pkg::*;

  logic [3:0] row_any;
  logic [1:0] row_sel;
  logic [3:0] cols;
  logic [1:0] col_sel;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_any[r] = |key_matrix_i[r*4 +: 4];
    end
    row_sel = 2'd0;
    for (int r = 3; r >= 0; r--) begin
      if (row_any[r]) begin
        row_sel = 2'(r);
      end
    end
    cols    = key_matrix_i[{row_sel, 2'b00} +: 4];
    col_sel = 2'd0;
    for (int c = 3; c >= 0; c--) begin
      if (cols[c]) begin
        col_sel = 2'(c);
      end
    end
  end

  assign item_o.key_valid = |row_any;
  assign item_o.key_index = {row_sel, col_sel};

endmodule

/* rtl/kcl_fifo.sv */
`include "assert_macros.svh"

module kcl_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kcl_pkg::item_t    item_i,
  output logic              full_o,
  input  logic              pop_i,
  output kcl_pkg::q_status_t status_o
);
  import kcl_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o             = (count_q == QCNT_W'(QDEPTH));
  assign status_o.not_empty = (count_q != '0);
  assign status_o.head      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `KCL_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0)
  `KCL_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i && full_o, pop_i)
  `KCL_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= QCNT_W'(QDEPTH))

endmodule

/* rtl/kcl_back.sv */
`include "assert_macros.svh"

module kcl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcl_pkg::cfg_wr_t   cfg_i,
  input  kcl_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               key_valid_o,
  output logic [3:0]         key_index_o,
  output logic               lock_open_o,
  output logic [1:0]         indicator_o,
  output logic [2:0]         command_o
);
  import kcl_pkg::*;

  key_t       code_q [CFG_N];
  key_t       keys_q [3];
  logic [1:0] count_q, count_d;
  logic       unl_q, unl_d;
  logic       out_valid_q;
  item_t      res_item_q;
  logic       res_open_q;
  ind_e       res_ind_q, ind;
  cmd_e       res_cmd_q, cmd;
  logic       match, wr_key;
  key_t       key;

  assign pop_o = status_i.not_empty && (!out_valid_q || !out_stall_i);
  assign key   = status_i.head.key_index;
  assign match = (keys_q[0] == code_q[CFG_CODE_FIRST])
              && (keys_q[1] == code_q[CFG_CODE_SECOND])
              && (keys_q[2] == code_q[CFG_CODE_THIRD])
              && (key == code_q[CFG_CODE_FOURTH]);

  always_comb begin
    unl_d   = unl_q;
    count_d = count_q;
    ind     = IND_NONE;
    cmd     = CMD_NONE;
    wr_key  = 1'b0;
    if (pop_o && status_i.head.key_valid) begin
      if (!unl_q) begin
        if (count_q == LAST_ENTRY) begin
          count_d = '0;
          unl_d   = match;
          ind     = match ? IND_GREEN : IND_RED;
        end else begin
          wr_key  = 1'b1;
          count_d = count_q + 2'd1;
          ind     = IND_BLUE;
        end
      end else if (key == KEY_D) begin
        unl_d   = 1'b0;
        count_d = '0;
        ind     = IND_RED;
      end else begin
        cmd = unlocked_command(key);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= CODE_RESET;
      count_q     <= '0;
      unl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        code_q[cfg_i.index] <= cfg_i.data;
      end
      count_q <= count_d;
      unl_q   <= unl_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      keys_q[count_q] <= key;
    end
    if (pop_o) begin
      res_item_q <= status_i.head;
      res_open_q <= unl_d;
      res_ind_q  <= ind;
      res_cmd_q  <= cmd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_valid_o = res_item_q.key_valid;
  assign key_index_o = res_item_q.key_index;
  assign lock_open_o = res_open_q;
  assign indicator_o = res_ind_q;
  assign command_o   = res_cmd_q;

  `KCL_ASSERT_IMP(a_green_open, clk_i, rst_ni, out_valid_q && res_ind_q == IND_GREEN,
                  res_open_q)
  `KCL_ASSERT_IMP(a_cmd_open, clk_i, rst_ni, out_valid_q && res_cmd_q != CMD_NONE,
                  res_open_q && res_item_q.key_valid)
  `KCL_ASSERT_IMP(a_count_locked, clk_i, rst_ni, count_q != '0, !unl_q)
  `KCL_ASSERT_NXT(a_relock_clears, clk_i, rst_ni, unl_q && !unl_d, count_q == '0)

endmodule

/* rtl/keypad_code_lock.sv */
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+------------------------------------
// input    | in        | in_valid / in_stall  | key_matrix
// output   | out       | out_valid / out_stall| key_valid key_index lock_open
//          |           |                      | indicator command
// config   | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One word per cycle sustained while out_stall is low; a word passes through the
// two-entry queue and the result register of the lock stage.
// Async active-low reset: code registers take their defaults, lock closed, queue empty.
// in_stall rises only when the queue is full and the result register cannot drain.
// Config is always ready and takes effect on the next decoded key.
module keypad_code_lock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] key_matrix_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        key_valid_o,
  output logic [3:0]  key_index_o,
  output logic        lock_open_o,
  output logic [1:0]  indicator_o,
  output logic [2:0]  command_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import kcl_pkg::*;

  item_t     front_item;
  q_status_t q_status;
  cfg_wr_t   cfg_wr;
  logic      q_full, q_push, q_pop;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign in_stall = q_full && !q_pop;
  assign q_push   = in_valid && !in_stall;

  kcl_front u_front (
    .key_matrix_i (key_matrix_i),
    .item_o       (front_item)
  );

  kcl_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .item_i   (front_item),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .status_o (q_status)
  );

  kcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .status_i    (q_status),
    .pop_o       (q_pop),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .key_valid_o (key_valid_o),
    .key_index_o (key_index_o),
    .lock_open_o (lock_open_o),
    .indicator_o (indicator_o),
    .command_o   (command_o)
  );

endmodule

/* tb/keypad_code_lock_checker.sv */
module keypad_code_lock_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] key_matrix_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        key_valid_i,
  input  logic [3:0]  key_index_i,
  input  logic        lock_open_i,
  input  logic [1:0]  indicator_i,
  input  logic [2:0]  command_i,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        lock_state_o,
  output logic [1:0]  entry_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcl_pkg::*;

  typedef struct packed {
    logic key_valid;
    key_t key_index;
    logic lock_open;
    ind_e indicator;
    cmd_e command;
  } lock_word_t;

  key_t       code_keys [CFG_N];
  key_t       entered [4];
  logic [1:0] entry_cnt;
  logic       unlocked_q;
  lock_word_t results_due [$];
  lock_word_t want;

  assign lock_state_o  = unlocked_q;
  assign entry_count_o = entry_cnt;

  function automatic lock_word_t apply_snapshot(logic [15:0] m);
    lock_word_t w;
    logic       hit;
    logic       same;
    w.key_valid = 1'b0;
    w.key_index = '0;
    w.indicator = IND_NONE;
    w.command   = CMD_NONE;
    hit = 1'b0;
    // lowest set bit is the first row with a key, lowest column in it
    for (int k = 0; k < 16; k++) begin
      if (!hit && m[k]) begin
        hit = 1'b1;
        w.key_index = key_t'(k);
      end
    end
    w.key_valid = hit;
    if (hit) begin
      if (!unlocked_q) begin
        entered[entry_cnt] = w.key_index;
        if (entry_cnt == LAST_ENTRY) begin
          entry_cnt = '0;
          same = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (entered[i] != code_keys[i]) same = 1'b0;
          end
          unlocked_q  = same;
          w.indicator = same ? IND_GREEN : IND_RED;
        end else begin
          entry_cnt   = entry_cnt + 2'd1;
          w.indicator = IND_BLUE;
        end
      end else if (w.key_index == KEY_D) begin
        unlocked_q  = 1'b0;
        entry_cnt   = '0;
        w.indicator = IND_RED;
      end else begin
        case (w.key_index)
          KEY_A:   w.command = CMD_PER_DOWN;
          KEY_B:   w.command = CMD_PER_UP;
          KEY_1:   w.command = CMD_TOGGLE;
          KEY_2:   w.command = CMD_UP_COUNT;
          KEY_3:   w.command = CMD_IN_OUT;
          KEY_0:   w.command = CMD_STATIC;
          default: w.command = CMD_NONE;
        endcase
      end
    end
    w.lock_open = unlocked_q;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_N; i++) code_keys[i] = CODE_RESET[i];
      for (int i = 0; i < 4; i++) entered[i] = '0;
      entry_cnt    = '0;
      unlocked_q   = 1'b0;
      results_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          if (key_valid_i !== want.key_valid) begin
            $error("key_valid: expected %0d, actual %0d", want.key_valid, key_valid_i);
            fail_count_o++;
          end
          if (key_index_i !== want.key_index) begin
            $error("key_index: expected %0d, actual %0d", want.key_index, key_index_i);
            fail_count_o++;
          end
          if (lock_open_i !== want.lock_open) begin
            $error("lock_open: expected %0d, actual %0d", want.lock_open, lock_open_i);
            fail_count_o++;
          end
          if (indicator_i !== want.indicator) begin
            $error("indicator: expected %0d, actual %0d", want.indicator, indicator_i);
            fail_count_o++;
          end
          if (command_i !== want.command) begin
            $error("command: expected %0d, actual %0d", want.command, command_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid && cfg_ready) code_keys[cfg_index_i] = cfg_data_i;
      if (in_valid && !in_stall) results_due.push_back(apply_snapshot(key_matrix_i));
      pending_o = results_due.size();
    end
  end

endmodule

/* tb/tb_keypad_code_lock.sv */
module tb_keypad_code_lock;
  timeunit 1ns;
  timeprecision 1ps;
  import kcl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_KEYS  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] key_matrix_i;
  logic        out_valid;
  logic        out_stall;
  logic        key_valid_o;
  logic [3:0]  key_index_o;
  logic        lock_open_o;
  logic [1:0]  indicator_o;
  logic [2:0]  command_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;

  int          fail_count;
  int          pending;
  logic        lock_state;
  logic [1:0]  entry_count;

  int          idle_pct;
  int          stall_pct;
  int          cycles;
  key_t        code_keys [CFG_N];
  key_t        cmd_keys [6] = '{KEY_A, KEY_B, KEY_1, KEY_2, KEY_3, KEY_0};

  keypad_code_lock u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_matrix_i (key_matrix_i),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_valid_o  (key_valid_o),
    .key_index_o  (key_index_o),
    .lock_open_o  (lock_open_o),
    .indicator_o  (indicator_o),
    .command_o    (command_o),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  keypad_code_lock_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key_matrix_i  (key_matrix_i),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .key_valid_i   (key_valid_o),
    .key_index_i   (key_index_o),
    .lock_open_i   (lock_open_o),
    .indicator_i   (indicator_o),
    .command_i     (command_o),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .lock_state_o  (lock_state),
    .entry_count_o (entry_count)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall = ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random upper bits, nothing below the key so it wins the priority
  function automatic logic [15:0] key_word(key_t k);
    logic [15:0] m;
    m = 16'($urandom);
    m &= ~((16'd1 << k) - 16'd1);
    m |= 16'd1 << k;
    return m;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [15:0] m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid     = 1'b1;
    key_matrix_i = m;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_code(cfg_idx_e idx, key_t val);
    wait_drained();
    cfg_valid   = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid      = 1'b0;
    code_keys[idx] = val;
  endtask

  task automatic run_phase(int n);
    int          sent;
    int          r;
    bit          honest;
    bit          paused;
    logic [15:0] m;
    sent   = 0;
    honest = 1'b1;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent == n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 8) begin
        m = (r < 3) ? 16'h0000 : 16'($urandom);
      end else if (lock_state) begin
        if (r < 25) m = key_word(KEY_D);
        else if (r < 70) m = key_word(cmd_keys[$urandom_range(5)]);
        else m = key_word(key_t'($urandom_range(14)));
      end else begin
        if (entry_count == 2'd0) honest = ($urandom_range(99) < 75);
        m = key_word(honest ? code_keys[entry_count] : key_t'($urandom_range(15)));
      end
      send_word(m);
      if (m != 16'h0000) sent++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    key_matrix_i = '0;
    cfg_valid    = 1'b0;
    cfg_index_i  = CFG_CODE_FIRST;
    cfg_data_i   = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    for (int i = 0; i < CFG_N; i++) code_keys[i] = CODE_RESET[i];
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default code 1 2 3 4, then every command, relock, a wrong code
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'hF002);
    send_word(16'h8004);
    send_word(16'hFFF0);
    send_word(16'h0008);
    send_word(16'h0080);
    send_word(16'h0001);
    send_word(16'h0002);
    send_word(16'h0004);
    send_word(16'h2000);
    send_word(16'h0020);
    send_word(16'h4000);
    send_word(16'h0000);
    send_word(16'h8000);
    repeat (4) send_word(16'h8000);
    send_word(16'h0000);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        3: begin idle_pct = 14; stall_pct = 14; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int i = 0; i < CFG_N; i++) begin
        case (p)
          1: write_code(cfg_idx_e'(i), 4'd0);
          2: write_code(cfg_idx_e'(i), 4'd15);
          4: write_code(cfg_idx_e'(i), $urandom_range(1) ? 4'd15 : 4'd0);
          default: write_code(cfg_idx_e'(i), key_t'($urandom_range(15)));
        endcase
      end
      run_phase(PHASE_KEYS);
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/kcl_pkg.sv
rtl/kcl_front.sv
rtl/kcl_fifo.sv
rtl/kcl_back.sv
rtl/keypad_code_lock.sv
tb/keypad_code_lock_checker.sv
tb/tb_keypad_code_lock.sv
